>>> design/assert_macros.svh
// Assertion macros shared by the refraction block.
// Needs a clock named clock and a reset named reset in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define FRD_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define FRD_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> design/frd_pkg.sv
// Package for the Fresnel and refraction block: payload types, stage side data,
// fixed-point constants and the output rounding function. No dependencies.
`timescale 1ns / 1ps
package frd_pkg;

   localparam int VecFracBits = 14;
   localparam int IorFracBits = 13;
   localparam int KrFracBits  = 14;
   localparam int Wb          = 24;

   localparam int VecW = 16;
   localparam int IorW = 15;
   localparam int KrW  = 15;

   localparam int CW     = Wb + 1;
   localparam int RW     = IorW + Wb - IorFracBits;
   localparam int EtaW   = Wb + 8;
   localparam int E2W    = 2 * EtaW - Wb - 1;
   localparam int RatW   = EtaW + 1;
   localparam int K2W    = EtaW + 1;
   localparam int IwW    = VecW + Wb - VecFracBits;
   localparam int PW     = EtaW + IwW - Wb;
   localparam int SumW   = PW + 2;
   localparam int DotW   = 2 * VecW + 2;

   localparam int CosShift    = 2 * VecFracBits - Wb;
   localparam int IorShift    = Wb - IorFracBits;
   localparam int VecShift    = Wb - VecFracBits;
   localparam int RoundShift  = Wb - KrFracBits;
   localparam int EtaSatLim   = 1 << (2 * Wb - EtaW);
   localparam int KrOne       = 1 << KrFracBits;
   localparam int KrHalf      = 1 << (RoundShift - 1);
   localparam int VecHalf     = 1 << (VecShift - 1);
   localparam int VecLim      = (VecFracBits >= 15) ? 32767 : (1 << VecFracBits);

   localparam logic [CW-1:0]   OneC   = {1'b1, {Wb{1'b0}}};
   localparam logic [EtaW-1:0] EtaMax = {1'b1, {(EtaW - 1){1'b0}}};

   typedef struct packed {
      logic signed [VecW-1:0] incident_x;
      logic signed [VecW-1:0] incident_y;
      logic signed [VecW-1:0] incident_z;
      logic signed [VecW-1:0] normal_x;
      logic signed [VecW-1:0] normal_y;
      logic signed [VecW-1:0] normal_z;
      logic [IorW-1:0]        refr_index;
   } req_type;

   typedef struct packed {
      logic [KrW-1:0]         reflectance;
      logic signed [VecW-1:0] refract_x;
      logic signed [VecW-1:0] refract_y;
      logic signed [VecW-1:0] refract_z;
      logic                   total_reflection;
      logic                   outside_hit;
   } rsp_type;

   typedef struct packed {
      logic [2:0][VecW-1:0] iv;
      logic [2:0][VecW-1:0] nv;
      logic [CW-1:0]        c;
      logic [RW-1:0]        r;
      logic                 outside;
      logic                 sat;
   } eta_side_type;

   typedef struct packed {
      logic [2:0][VecW-1:0] iv;
      logic [2:0][VecW-1:0] nv;
      logic [CW-1:0]        c;
      logic [EtaW-1:0]      eta;
      logic [EtaW-1:0]      ecc;
      logic                 outside;
      logic                 tir;
   } sqrt_side_type;

   typedef struct packed {
      logic [2:0][VecW-1:0]  iv;
      logic [2:0][VecW-1:0]  nv;
      logic [EtaW-1:0]       eta;
      logic signed [K2W-1:0] k2;
      logic                  outside;
      logic                  tir;
      logic                  rs_zero;
   } rat_side_type;

   // Rounds a Q.24 value half away from zero to the output format and saturates it.
   function automatic logic [VecW-1:0] round_vec(input logic signed [SumW-1:0] v);
      logic [SumW-1:0] mag;
      logic [SumW-1:0] rnd;
      logic [VecW-1:0] lim;
      mag = v[SumW-1] ? SumW'(-v) : SumW'(v);
      rnd = (mag + SumW'(VecHalf)) >> VecShift;
      lim = (rnd > SumW'(VecLim)) ? VecW'(VecLim) : rnd[VecW-1:0];
      return v[SumW-1] ? VecW'(-lim) : lim;
   endfunction

endpackage

>>> design/frd_div.sv
// Pipelined restoring divider, one quotient bit per stage, with side data.
// Stand-alone; the partial remainder given at the input must be below the divisor.
`timescale 1ns / 1ps
module frd_div #(
   parameter int DenW  = 26,
   parameter int QuoW  = 32,
   parameter int SideW = 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic             in_valid,
   input  logic [DenW-1:0]  in_rem,
   input  logic [DenW-1:0]  in_den,
   input  logic [QuoW-1:0]  in_low,
   input  logic [SideW-1:0] in_side,
   output logic             out_valid,
   output logic [QuoW-1:0]  out_quo,
   output logic [SideW-1:0] out_side
);

   logic             vld_ff  [QuoW];
   logic [DenW-1:0]  rem_ff  [QuoW];
   logic [DenW-1:0]  den_ff  [QuoW];
   logic [QuoW-1:0]  low_ff  [QuoW];
   logic [SideW-1:0] side_ff [QuoW];

   for (genvar k = 0; k < QuoW; k++) begin : g_stage
      logic             vld_i;
      logic [DenW-1:0]  rem_i;
      logic [DenW-1:0]  den_i;
      logic [QuoW-1:0]  low_i;
      logic [SideW-1:0] side_i;
      logic [DenW:0]    trial;
      logic [DenW-1:0]  rem_in;
      logic [QuoW-1:0]  low_in;

      if (k == 0) begin : g_head
         assign vld_i  = in_valid;
         assign rem_i  = in_rem;
         assign den_i  = in_den;
         assign low_i  = in_low;
         assign side_i = in_side;
      end else begin : g_body
         assign vld_i  = vld_ff[k-1];
         assign rem_i  = rem_ff[k-1];
         assign den_i  = den_ff[k-1];
         assign low_i  = low_ff[k-1];
         assign side_i = side_ff[k-1];
      end

      always_comb begin
         trial = {rem_i, low_i[QuoW-1]};
         if (trial >= {1'b0, den_i}) begin
            rem_in = DenW'(trial - {1'b0, den_i});
            low_in = {low_i[QuoW-2:0], 1'b1};
         end else begin
            rem_in = trial[DenW-1:0];
            low_in = {low_i[QuoW-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (en) begin
            vld_ff[k] <= vld_i;
         end
         if (en) begin
            rem_ff[k]  <= rem_in;
            den_ff[k]  <= den_i;
            low_ff[k]  <= low_in;
            side_ff[k] <= side_i;
         end
      end
   end

   assign out_valid = vld_ff[QuoW-1];
   assign out_quo   = low_ff[QuoW-1];
   assign out_side  = side_ff[QuoW-1];

endmodule

>>> design/frd_sqrt.sv
// Pipelined floor square root, one root bit per stage, with side data.
// Stand-alone; the radicand is twice the root width.
`timescale 1ns / 1ps
module frd_sqrt #(
   parameter int RootW = 25,
   parameter int SideW = 1
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               in_valid,
   input  logic [2*RootW-1:0] in_x,
   input  logic [SideW-1:0]   in_side,
   output logic               out_valid,
   output logic [RootW-1:0]   out_root,
   output logic [SideW-1:0]   out_side
);

   localparam int DW = 2 * RootW;

   logic             vld_ff  [RootW];
   logic [DW-1:0]    rem_ff  [RootW];
   logic [RootW-1:0] root_ff [RootW];
   logic [SideW-1:0] side_ff [RootW];

   for (genvar k = 0; k < RootW; k++) begin : g_stage
      localparam int Bit = RootW - 1 - k;
      logic             vld_i;
      logic [DW-1:0]    rem_i;
      logic [RootW-1:0] root_i;
      logic [SideW-1:0] side_i;
      logic [DW-1:0]    step;
      logic [DW-1:0]    rem_in;
      logic [RootW-1:0] root_in;

      if (k == 0) begin : g_head
         assign vld_i  = in_valid;
         assign rem_i  = in_x;
         assign root_i = '0;
         assign side_i = in_side;
      end else begin : g_body
         assign vld_i  = vld_ff[k-1];
         assign rem_i  = rem_ff[k-1];
         assign root_i = root_ff[k-1];
         assign side_i = side_ff[k-1];
      end

      always_comb begin
         step = (DW'(root_i) << (Bit + 1)) | (DW'(1) << (2 * Bit));
         if (rem_i >= step) begin
            rem_in  = rem_i - step;
            root_in = root_i | (RootW'(1) << Bit);
         end else begin
            rem_in  = rem_i;
            root_in = root_i;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (en) begin
            vld_ff[k] <= vld_i;
         end
         if (en) begin
            rem_ff[k]  <= rem_in;
            root_ff[k] <= root_in;
            side_ff[k] <= side_i;
         end
      end
   end

   assign out_valid = vld_ff[RootW-1];
   assign out_root  = root_ff[RootW-1];
   assign out_side  = side_ff[RootW-1];

endmodule

>>> design/dielectric_fresnel_refract_top.sv
// Channel   Ports                           Moves
// req       req_valid req_ready req_data    one request: directions and index
// rsp       rsp_valid rsp_ready rsp_data    reflectance, refraction, flags
//
// One request is accepted per cycle while the output buffer has room. A result passes
// through 32 quotient bit stages for the index reciprocal, 25 root bit stages, 25 stages
// of the two parallel ratio dividers, the other register stages and the output buffer.
// Reset is synchronous and clears every valid bit and the two-entry output buffer.
// The pipeline advances while the output buffer has room, so one waiting result
// does not stop the flow; a stall freezes every stage in place.
// Uses frd_pkg, frd_div, frd_sqrt and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module dielectric_fresnel_refract_top import frd_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   logic en;

   // Stage 1: products of the dot product.
   logic                     s1_vld_ff;
   req_type                  s1_req_ff;
   logic signed [2*VecW-1:0] s1_prod_ff [3];
   logic signed [2*VecW-1:0] prod_in    [3];

   always_comb begin
      prod_in[0] = req_data.incident_x * req_data.normal_x;
      prod_in[1] = req_data.incident_y * req_data.normal_y;
      prod_in[2] = req_data.incident_z * req_data.normal_z;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (en) begin
         s1_vld_ff <= req_valid && req_ready;
      end
      if (en) begin
         s1_req_ff <= req_data;
         for (int k = 0; k < 3; k++) begin
            s1_prod_ff[k] <= prod_in[k];
         end
      end
   end

   // Cosine, side and index, then the reciprocal of the index.
   logic signed [DotW-1:0] dot;
   logic [DotW-1:0]        dot_mag;
   logic [DotW-1:0]        c_full;
   logic [RW-1:0]          r_val;
   eta_side_type           eta_side;

   always_comb begin
      dot     = DotW'(s1_prod_ff[0]) + DotW'(s1_prod_ff[1]) + DotW'(s1_prod_ff[2]);
      dot_mag = dot[DotW-1] ? DotW'(-dot) : DotW'(dot);
      c_full  = dot_mag >> CosShift;
      r_val   = RW'(s1_req_ff.refr_index) << IorShift;
      if (r_val == '0) begin
         r_val = RW'(1);
      end
      eta_side.iv      = {s1_req_ff.incident_z, s1_req_ff.incident_y, s1_req_ff.incident_x};
      eta_side.nv      = {s1_req_ff.normal_z, s1_req_ff.normal_y, s1_req_ff.normal_x};
      eta_side.c       = (c_full > DotW'(OneC)) ? OneC : c_full[CW-1:0];
      eta_side.r       = r_val;
      eta_side.outside = dot[DotW-1];
      eta_side.sat     = r_val <= RW'(EtaSatLim);
   end

   logic                        eta_vld;
   logic [EtaW-1:0]             eta_q;
   logic [$bits(eta_side_type)-1:0] eta_side_out;
   eta_side_type                eta_done;

   frd_div #(
      .DenW  (RW),
      .QuoW  (EtaW),
      .SideW ($bits(eta_side_type))
   ) u_eta_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s1_vld_ff),
      .in_rem    (eta_side.sat ? RW'(0) : RW'(EtaSatLim)),
      .in_den    (r_val),
      .in_low    ('0),
      .in_side   (eta_side),
      .out_valid (eta_vld),
      .out_quo   (eta_q),
      .out_side  (eta_side_out)
   );

   assign eta_done = eta_side_out;

   // Stage 3: relative index.
   logic          s3_vld_ff;
   sqrt_side_type s3_side_ff;
   sqrt_side_type s3_side_in;

   always_comb begin
      s3_side_in.iv      = eta_done.iv;
      s3_side_in.nv      = eta_done.nv;
      s3_side_in.c       = eta_done.c;
      s3_side_in.outside = eta_done.outside;
      s3_side_in.ecc     = '0;
      s3_side_in.tir     = 1'b0;
      if (!eta_done.outside) begin
         s3_side_in.eta = EtaW'(eta_done.r);
      end else if (eta_done.sat || eta_q > EtaMax) begin
         s3_side_in.eta = EtaMax;
      end else begin
         s3_side_in.eta = eta_q;
      end
   end

   // Stage 4: squares of cosine and index, index times cosine.
   logic            s4_vld_ff;
   sqrt_side_type   s4_side_ff;
   sqrt_side_type   s4_side_in;
   logic [2*CW-1:0] s4_cc_ff;
   logic [E2W-1:0]  s4_e2_ff;
   logic [2*EtaW-1:0]  ee_full;
   logic [EtaW+CW-1:0] ec_full;
   logic [2*CW-1:0]    cc_full;

   always_comb begin
      ee_full = s3_side_ff.eta * s3_side_ff.eta;
      ec_full = s3_side_ff.eta * s3_side_ff.c;
      cc_full = s3_side_ff.c * s3_side_ff.c;
      s4_side_in     = s3_side_ff;
      s4_side_in.ecc = ec_full[Wb +: EtaW];
   end

   // Stage 5: squared sine of the transmitted angle.
   logic           s5_vld_ff;
   sqrt_side_type  s5_side_ff;
   logic [E2W-1:0] s5_st2_ff;
   logic [CW-1:0]  s2i;
   logic [E2W+CW-1:0] st2_full;

   always_comb begin
      s2i      = OneC - s4_cc_ff[Wb +: CW];
      st2_full = s4_e2_ff * s2i;
   end

   // Stage 6: total reflection test and radicand.
   logic            s6_vld_ff;
   sqrt_side_type   s6_side_ff;
   sqrt_side_type   s6_side_in;
   logic [2*CW-1:0] s6_x_ff;
   logic            tir_in;
   logic [CW-1:0]   cos2_in;

   always_comb begin
      tir_in  = s5_st2_ff >= E2W'(OneC);
      cos2_in = CW'(E2W'(OneC) - s5_st2_ff);
      s6_side_in     = s5_side_ff;
      s6_side_in.tir = tir_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_vld_ff <= 1'b0;
         s4_vld_ff <= 1'b0;
         s5_vld_ff <= 1'b0;
         s6_vld_ff <= 1'b0;
      end else if (en) begin
         s3_vld_ff <= eta_vld;
         s4_vld_ff <= s3_vld_ff;
         s5_vld_ff <= s4_vld_ff;
         s6_vld_ff <= s5_vld_ff;
      end
      if (en) begin
         s3_side_ff     <= s3_side_in;
         s4_side_ff     <= s4_side_in;
         s4_cc_ff       <= cc_full;
         s4_e2_ff       <= ee_full[Wb +: E2W];
         s5_side_ff     <= s4_side_ff;
         s5_st2_ff      <= st2_full[Wb +: E2W];
         s6_side_ff     <= s6_side_in;
         s6_x_ff        <= tir_in ? '0 : ((2 * CW)'(cos2_in) << Wb);
      end
   end

   // Cosine of the transmitted angle.
   logic                             sq_vld;
   logic [CW-1:0]                    cost;
   logic [$bits(sqrt_side_type)-1:0] sq_side_out;
   sqrt_side_type                    sq_done;

   frd_sqrt #(
      .RootW (CW),
      .SideW ($bits(sqrt_side_type))
   ) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s6_vld_ff),
      .in_x      (s6_x_ff),
      .in_side   (s6_side_ff),
      .out_valid (sq_vld),
      .out_root  (cost),
      .out_side  (sq_side_out)
   );

   assign sq_done = sq_side_out;

   // Stage 7: index times transmitted cosine.
   logic          s7_vld_ff;
   sqrt_side_type s7_side_ff;
   logic [CW-1:0] s7_cost_ff;
   logic [EtaW-1:0] s7_ec_ff;
   logic [EtaW+CW-1:0] etc_full;

   assign etc_full = sq_done.eta * cost;

   // Stage 8: Fresnel ratio operands.
   logic            s8_vld_ff;
   rat_side_type    s8_side_ff;
   logic [RatW-1:0] s8_rs_num_ff;
   logic [RatW-1:0] s8_rs_den_ff;
   logic [RatW-1:0] s8_rp_num_ff;
   logic [RatW-1:0] s8_rp_den_ff;
   logic            s8_rp_zero_ff;
   logic [RatW-1:0] rs_a, rs_b, rp_a, rp_b;
   rat_side_type    s8_side_in;

   always_comb begin
      rs_a = RatW'(s7_side_ff.c);
      rs_b = RatW'(s7_ec_ff);
      rp_a = RatW'(s7_side_ff.ecc);
      rp_b = RatW'(s7_cost_ff);
      s8_side_in.iv      = s7_side_ff.iv;
      s8_side_in.nv      = s7_side_ff.nv;
      s8_side_in.eta     = s7_side_ff.eta;
      s8_side_in.k2      = $signed(K2W'(s7_side_ff.ecc)) - $signed(K2W'(s7_cost_ff));
      s8_side_in.outside = s7_side_ff.outside;
      s8_side_in.tir     = s7_side_ff.tir;
      s8_side_in.rs_zero = (rs_a + rs_b) == '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s7_vld_ff <= 1'b0;
         s8_vld_ff <= 1'b0;
      end else if (en) begin
         s7_vld_ff <= sq_vld;
         s8_vld_ff <= s7_vld_ff;
      end
      if (en) begin
         s7_side_ff    <= sq_done;
         s7_cost_ff    <= cost;
         s7_ec_ff      <= etc_full[Wb +: EtaW];
         s8_side_ff    <= s8_side_in;
         s8_rs_num_ff  <= (rs_a > rs_b) ? rs_a - rs_b : rs_b - rs_a;
         s8_rs_den_ff  <= rs_a + rs_b;
         s8_rp_num_ff  <= (rp_a > rp_b) ? rp_a - rp_b : rp_b - rp_a;
         s8_rp_den_ff  <= rp_a + rp_b;
         s8_rp_zero_ff <= (rp_a + rp_b) == '0;
      end
   end

   logic                            rs_vld;
   logic [CW-1:0]                   rs_q;
   logic [$bits(rat_side_type)-1:0] rs_side_out;
   rat_side_type                    rat_done;
   logic                            rp_vld;
   logic [CW-1:0]                   rp_q;
   logic                            rp_zero;

   frd_div #(
      .DenW  (RatW),
      .QuoW  (CW),
      .SideW ($bits(rat_side_type))
   ) u_rs_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s8_vld_ff),
      .in_rem    (s8_rs_num_ff >> 1),
      .in_den    (s8_rs_den_ff),
      .in_low    ({s8_rs_num_ff[0], {Wb{1'b0}}}),
      .in_side   (s8_side_ff),
      .out_valid (rs_vld),
      .out_quo   (rs_q),
      .out_side  (rs_side_out)
   );

   frd_div #(
      .DenW  (RatW),
      .QuoW  (CW),
      .SideW (1)
   ) u_rp_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s8_vld_ff),
      .in_rem    (s8_rp_num_ff >> 1),
      .in_den    (s8_rp_den_ff),
      .in_low    ({s8_rp_num_ff[0], {Wb{1'b0}}}),
      .in_side   (s8_rp_zero_ff),
      .out_valid (rp_vld),
      .out_quo   (rp_q),
      .out_side  (rp_zero)
   );

   assign rat_done = rs_side_out;

   // Stage 9: squared ratios and refraction products.
   logic           s9_vld_ff;
   logic           s9_tir_ff;
   logic           s9_outside_ff;
   logic [CW-1:0]  s9_rs2_ff;
   logic [CW-1:0]  s9_rp2_ff;
   logic [PW-1:0]  s9_pe_ff [3];
   logic [PW-1:0]  s9_pk_ff [3];
   logic           s9_se_ff [3];
   logic           s9_sk_ff [3];
   logic [CW-1:0]  rs_val, rp_val;
   logic [2*CW-1:0] rs_sq, rp_sq;
   logic [K2W-2:0] k2_mag;
   logic [VecW-1:0] iv_mag [3];
   logic [VecW-1:0] nv_mag [3];
   logic [EtaW+IwW-1:0] pe_full [3];
   logic [EtaW+IwW-1:0] pk_full [3];

   always_comb begin
      rs_val = rat_done.rs_zero ? OneC : rs_q;
      rp_val = rp_zero ? OneC : rp_q;
      rs_sq  = rs_val * rs_val;
      rp_sq  = rp_val * rp_val;
      k2_mag = rat_done.k2[K2W-1] ? (K2W - 1)'(-rat_done.k2) : (K2W - 1)'(rat_done.k2);
      for (int k = 0; k < 3; k++) begin
         iv_mag[k]  = rat_done.iv[k][VecW-1] ? VecW'(-rat_done.iv[k]) : rat_done.iv[k];
         nv_mag[k]  = rat_done.nv[k][VecW-1] ? VecW'(-rat_done.nv[k]) : rat_done.nv[k];
         pe_full[k] = rat_done.eta * (IwW'(iv_mag[k]) << VecShift);
         pk_full[k] = k2_mag * (IwW'(nv_mag[k]) << VecShift);
      end
   end

   // Stage 10: sums.
   logic                   s10_vld_ff;
   logic                   s10_tir_ff;
   logic                   s10_outside_ff;
   logic [CW-1:0]          s10_kr_ff;
   logic signed [SumW-1:0] s10_v_ff [3];
   logic signed [SumW-1:0] v_in [3];
   logic [CW:0]            kr_sum;

   always_comb begin
      kr_sum = (CW + 1)'(s9_rs2_ff) + (CW + 1)'(s9_rp2_ff);
      for (int k = 0; k < 3; k++) begin
         v_in[k] = (s9_se_ff[k] ? -SumW'(s9_pe_ff[k]) : SumW'(s9_pe_ff[k]))
                 + (s9_sk_ff[k] ? -SumW'(s9_pk_ff[k]) : SumW'(s9_pk_ff[k]));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s9_vld_ff  <= 1'b0;
         s10_vld_ff <= 1'b0;
      end else if (en) begin
         s9_vld_ff  <= rs_vld && rp_vld;
         s10_vld_ff <= s9_vld_ff;
      end
      if (en) begin
         s9_tir_ff     <= rat_done.tir;
         s9_outside_ff <= rat_done.outside;
         s9_rs2_ff     <= rs_sq[Wb +: CW];
         s9_rp2_ff     <= rp_sq[Wb +: CW];
         for (int k = 0; k < 3; k++) begin
            s9_pe_ff[k] <= pe_full[k][Wb +: PW];
            s9_pk_ff[k] <= pk_full[k][Wb +: PW];
            s9_se_ff[k] <= rat_done.iv[k][VecW-1];
            s9_sk_ff[k] <= rat_done.k2[K2W-1] ^ rat_done.nv[k][VecW-1] ^ !rat_done.outside;
         end
         s10_tir_ff     <= s9_tir_ff;
         s10_outside_ff <= s9_outside_ff;
         s10_kr_ff      <= kr_sum[CW:1];
         for (int k = 0; k < 3; k++) begin
            s10_v_ff[k] <= v_in[k];
         end
      end
   end

   // Output rounding and the two-entry output buffer.
   rsp_type     rsp_in;
   logic [CW:0] kr_rnd;

   always_comb begin
      kr_rnd = ((CW + 1)'(s10_kr_ff) + (CW + 1)'(KrHalf)) >> RoundShift;
      rsp_in.total_reflection = s10_tir_ff;
      rsp_in.outside_hit      = s10_outside_ff;
      if (s10_tir_ff) begin
         rsp_in.reflectance = KrW'(KrOne);
         rsp_in.refract_x   = '0;
         rsp_in.refract_y   = '0;
         rsp_in.refract_z   = '0;
      end else begin
         rsp_in.reflectance = (kr_rnd > (CW + 1)'(KrOne)) ? KrW'(KrOne) : KrW'(kr_rnd);
         rsp_in.refract_x   = round_vec(s10_v_ff[0]);
         rsp_in.refract_y   = round_vec(s10_v_ff[1]);
         rsp_in.refract_z   = round_vec(s10_v_ff[2]);
      end
   end

   rsp_type    buf_ff [2];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] cnt_ff;
   logic       push;
   logic       pop;
   logic       tir_ok;

   assign en        = cnt_ff != 2'd2;
   assign req_ready = en;
   assign push      = en && s10_vld_ff;
   assign rsp_valid = cnt_ff != 2'd0;
   assign pop       = rsp_valid && rsp_ready;
   assign rsp_data  = buf_ff[rd_ptr_ff];
   assign tir_ok    = rsp_data.reflectance == KrW'(KrOne) && rsp_data.refract_x == '0
                   && rsp_data.refract_y == '0 && rsp_data.refract_z == '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         cnt_ff <= cnt_ff + 2'(push) - 2'(pop);
      end
      if (push) begin
         buf_ff[wr_ptr_ff] <= rsp_in;
      end
   end

   `FRD_ASSERT_IMP(a_tir_result, rsp_valid && rsp_data.total_reflection, tir_ok, "bad total reflection")
   `FRD_ASSERT_IMP(a_kr_range, rsp_valid, rsp_data.reflectance <= KrW'(KrOne), "reflectance above one")
   `FRD_ASSERT_NXT(a_stall_hold, s10_vld_ff && !en, s10_vld_ff, "stalled result lost")
   `FRD_ASSERT_IMP(a_div_align, rs_vld || rp_vld, rs_vld == rp_vld, "ratio dividers out of step")

endmodule
